/* design/bdq_pkg.sv */
// Shared types, widths and codes for the bounded deque with search.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  localparam int OP_W = 3;
  localparam int HW = 32;
  localparam int TW = 16;
  localparam int ST_W = 2;
  localparam int LEN_W = 5;

  localparam int CMD_Q_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_HAS_HANDLE = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_HAS_TID    = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_PUSH,
    CK_POP,
    CK_SEARCH,
    CK_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic            at_front;
    logic            by_tid;
    logic            remove;
    logic [HW-1:0]   handle;
    logic [TW-1:0]   tid;
  } cmd_t;

  typedef struct packed {
    logic [HW-1:0] handle;
    logic [TW-1:0] tid;
  } entry_t;

  // Physical slot of a queue position, circular from the front slot.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                            input logic [PW-1:0] pos);
    logic [PW:0] s;
    s = {{(PW + 1 - IW){1'b0}}, front} + {1'b0, pos};
    if (s >= (PW + 1)'(DEPTH)) begin
      s = s - (PW + 1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/bdq_if.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface bdq_req_if;
  import bdq_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [HW-1:0]   handle;
  logic [TW-1:0]   thread_id;

  modport source (output valid, operation, handle, thread_id, input ready);
  modport sink (input valid, operation, handle, thread_id, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [HW-1:0]    front_handle;
  logic [HW-1:0]    back_handle;
  logic [LEN_W-1:0] length;

  modport source (output valid, status, front_handle, back_handle, length, input ready);
  modport sink (input valid, status, front_handle, back_handle, length, output ready);
endinterface
`default_nettype wire

/* design/bdq_front.sv */
// Request intake: decodes the operation code into a command and holds it.
`timescale 1ns / 1ps
`default_nettype none
module bdq_front (
  input  logic            clk,
  input  logic            rst,
  bdq_req_if.sink         req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output bdq_pkg::cmd_t   cmd
);
  import bdq_pkg::*;

  cmd_t decoded;
  logic held;

  always_comb begin
    decoded.kind     = CK_NOP;
    decoded.at_front = 1'b0;
    decoded.by_tid   = 1'b0;
    decoded.remove   = 1'b0;
    decoded.handle   = req.handle;
    decoded.tid      = req.thread_id;
    unique case (req.operation)
      OP_PUSH_FRONT: begin
        decoded.kind     = CK_PUSH;
        decoded.at_front = 1'b1;
      end
      OP_PUSH_BACK: begin
        decoded.kind = CK_PUSH;
      end
      OP_POP_FRONT: begin
        decoded.kind     = CK_POP;
        decoded.at_front = 1'b1;
      end
      OP_POP_BACK: begin
        decoded.kind = CK_POP;
      end
      OP_HAS_HANDLE: begin
        decoded.kind = CK_SEARCH;
      end
      OP_REMOVE: begin
        decoded.kind   = CK_SEARCH;
        decoded.remove = 1'b1;
      end
      OP_HAS_TID: begin
        decoded.kind   = CK_SEARCH;
        decoded.by_tid = 1'b1;
      end
      default: begin
        decoded.kind = CK_NOP;
      end
    endcase
  end

  assign req.ready = !held || cmd_ready;
  assign cmd_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        held <= 1'b1;
        cmd  <= decoded;
      end else if (cmd_ready) begin
        held <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* design/bdq_cmd_fifo.sv */
// Short command queue between intake and the deque sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bdq_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bdq_pkg::cmd_t   wr_cmd,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bdq_pkg::cmd_t   rd_cmd
);
  import bdq_pkg::*;

  localparam int QW = $clog2(CMD_Q_DEPTH);

  cmd_t             slots [CMD_Q_DEPTH];
  logic [QW-1:0]    wr_ptr;
  logic [QW-1:0]    rd_ptr;
  logic [QW:0]      fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != (QW + 1)'(CMD_Q_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
    return (p == QW'(CMD_Q_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_cmd;
        wr_ptr        <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + (QW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QW + 1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* design/bdq_back.sv */
// Deque sequencer: entry store, push/pop, search walk, gap closing, result register.
`timescale 1ns / 1ps
`default_nettype none
module bdq_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bdq_pkg::cmd_t   cmd,
  bdq_rsp_if.source       rsp
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RDF,
    S_RDB,
    S_FIN
  } state_t;

  state_t           state;
  logic [IW-1:0]    front_index;
  logic [PW-1:0]    entry_count;
  entry_t           store [DEPTH];
  entry_t           rd_q;
  logic [IW-1:0]    rd_addr;
  logic             we;
  logic [IW-1:0]    wa;
  entry_t           wd;

  logic [PW-1:0]    sp;
  logic [PW-1:0]    cp;
  logic [PW-1:0]    wp;
  logic             cv;
  logic [HW-1:0]    key_h;
  logic [TW-1:0]    key_t;
  logic             by_tid;
  logic             remove;
  status_t          status;
  logic [HW-1:0]    front_h;

  logic             rsp_valid;
  logic [ST_W-1:0]  rsp_status;
  logic [HW-1:0]    rsp_front;
  logic [HW-1:0]    rsp_back;
  logic [LEN_W-1:0] rsp_length;

  logic             full;
  logic             empty;
  logic [PW-1:0]    last_pos;
  logic [IW-1:0]    front_dec;
  logic             match;

  assign full      = entry_count == PW'(DEPTH);
  assign empty     = entry_count == '0;
  assign last_pos  = entry_count - PW'(1);
  assign front_dec = (front_index == '0) ? IW'(DEPTH - 1) : front_index - IW'(1);
  assign match     = cv && (by_tid ? (rd_q.tid == key_t) : (rd_q.handle == key_h));
  assign cmd_ready = state == S_IDLE;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.front_handle = rsp_front;
  assign rsp.back_handle  = rsp_back;
  assign rsp.length       = rsp_length;

  always_comb begin
    unique case (state)
      S_SEARCH, S_SHIFT: rd_addr = slot_of(front_index, sp);
      S_RDB, S_FIN:      rd_addr = slot_of(front_index, last_pos);
      default:           rd_addr = front_index;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = front_index;
    wd = rd_q;
    if (state == S_IDLE && cmd_valid && cmd.kind == CK_PUSH && !full) begin
      we        = 1'b1;
      wa        = cmd.at_front ? front_dec : slot_of(front_index, entry_count);
      wd.handle = cmd.handle;
      wd.tid    = cmd.tid;
    end else if (state == S_SHIFT && cv) begin
      we = 1'b1;
      wa = slot_of(front_index, wp);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
    rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
      cv          <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key_h  <= cmd.handle;
            key_t  <= cmd.tid;
            by_tid <= cmd.by_tid;
            remove <= cmd.remove;
            cv     <= 1'b0;
            sp     <= '0;
            case (cmd.kind)
              CK_PUSH: begin
                state <= S_RDF;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_DONE;
                  if (cmd.at_front) begin
                    front_index <= front_dec;
                  end
                  entry_count <= entry_count + PW'(1);
                end
              end
              CK_POP: begin
                state <= S_RDF;
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  status <= ST_DONE;
                  if (cmd.at_front) begin
                    front_index <= slot_of(front_index, PW'(1));
                  end
                  entry_count <= last_pos;
                end
              end
              CK_SEARCH: begin
                if (empty) begin
                  status <= ST_NOT_FOUND;
                  state  <= S_RDF;
                end else begin
                  status <= ST_DONE;
                  state  <= S_SEARCH;
                end
              end
              default: begin
                status <= ST_DONE;
                state  <= S_RDF;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (match) begin
            if (remove) begin
              wp    <= cp;
              sp    <= cp + PW'(1);
              cv    <= 1'b0;
              state <= S_SHIFT;
            end else begin
              state <= S_RDF;
            end
          end else if (cv && cp == last_pos) begin
            status <= ST_NOT_FOUND;
            state  <= S_RDF;
          end else begin
            cv <= 1'b1;
            cp <= sp;
            sp <= sp + PW'(1);
          end
        end
        S_SHIFT: begin
          if (wp == last_pos && !cv) begin
            entry_count <= last_pos;
            state       <= S_RDF;
          end else begin
            if (cv) begin
              wp <= wp + PW'(1);
            end
            cv <= sp < entry_count;
            if (sp < entry_count) begin
              sp <= sp + PW'(1);
            end
          end
        end
        S_RDF: begin
          state <= S_RDB;
        end
        S_RDB: begin
          front_h <= rd_q.handle;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status;
            rsp_front  <= empty ? '0 : front_h;
            rsp_back   <= empty ? '0 : rd_q.handle;
            rsp_length <= LEN_W'(entry_count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/bounded_deque_with_search_unit.sv */
// Top level of the bounded deque of thread entries with handle and thread id search.
//
// Channels: req (sink) carries operation, handle and thread_id; rsp (source) returns
// status, front_handle, back_handle and length. A word moves when valid and ready
// are both high at a rising edge of clk. Every request word yields one response word.
// Requests are decoded at intake and wait in a two-entry command queue, so intake
// keeps accepting while the sequencer works or a response waits to be taken.
// The sequencer takes a new command word only once the last one's response is
// registered. Its steps per word: push, pop and unused codes do the step alone;
// has handle and has thread id walk from the front (one entry compared per cycle);
// remove searches by handle, then closes the gap (one entry moved per cycle).
// The entry store has one write and one registered read port; the front and back
// handles of every response are read back from it after the step.
// Reset (rst, synchronous, active high) empties the deque and the command queue and
// drops any pending response; the store contents are not cleared.
// When the receiver stalls, the response register holds its word, the sequencer waits
// before writing the next one, and intake stalls once the command queue is full.
`timescale 1ns / 1ps
`default_nettype none
module bounded_deque_with_search_unit (
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);
  import bdq_pkg::*;

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  bdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  bdq_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_cmd   (bk_cmd)
  );

  bdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .rsp       (rsp)
  );
endmodule
`default_nettype wire
